FILE: hdl/ratalu_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helper functions for the rational ALU.
// No dependencies; every other file in hdl/ imports this package.
package ratalu_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_W             = 33;
  localparam int SHIFT_W           = 5;
  localparam int DEC_SHIFT_W       = 4;
  localparam int STATUS_W          = 3;
  localparam int DIGIT_W           = 4;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FRAC  = 3'd0,
    ST_ZERO  = 3'd1,
    ST_INT   = 3'd2,
    ST_DEC   = 3'd3,
    ST_UNDEF = 3'd4
  } status_t;

  // Trial divisors, in the order the strip pass visits them
  typedef enum logic [2:0] {
    P_2  = 3'd0,
    P_3  = 3'd1,
    P_5  = 3'd2,
    P_7  = 3'd3,
    P_10 = 3'd4,
    P_11 = 3'd5,
    P_13 = 3'd6
  } prime_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_MUL_C,
    S_COMB,
    S_CHECK,
    S_TRIAL,
    S_WAIT,
    S_TEN,
    S_TEN_WAIT,
    S_CLASS,
    S_OUT
  } state_t;

  typedef struct packed {
    logic   start;
    prime_t sel;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic n_div;
    logic d_div;
  } div_sts_t;

  function automatic logic [DIGIT_W-1:0] prime_val(input prime_t p);
    logic [DIGIT_W-1:0] v;
    case (p)
      P_2:     v = 4'd2;
      P_3:     v = 4'd3;
      P_5:     v = 4'd5;
      P_7:     v = 4'd7;
      P_10:    v = 4'd10;
      P_11:    v = 4'd11;
      P_13:    v = 4'd13;
      default: v = 4'd2;
    endcase
    return v;
  endfunction

  function automatic prime_t next_prime(input prime_t p);
    prime_t n;
    case (p)
      P_2:     n = P_3;
      P_3:     n = P_5;
      P_5:     n = P_7;
      P_7:     n = P_10;
      P_10:    n = P_11;
      P_11:    n = P_13;
      default: n = P_13;
    endcase
    return n;
  endfunction

  // One radix-16 long-division step: {rem, digit} / p, with rem < p.
  // Returns {quotient digit, new remainder}.
  function automatic logic [2*DIGIT_W-1:0] div_step(input logic [DIGIT_W-1:0] rem,
                                                    input logic [DIGIT_W-1:0] digit,
                                                    input logic [DIGIT_W-1:0] p);
    logic [2*DIGIT_W-1:0] x;
    logic [2*DIGIT_W-1:0] sub;
    logic [DIGIT_W-1:0]   q;
    x = {rem, digit};
    q = '0;
    for (int k = DIGIT_W - 1; k >= 0; k--) begin
      sub = {{DIGIT_W{1'b0}}, p} << k;
      if (x >= sub) begin
        x    = x - sub;
        q[k] = 1'b1;
      end
    end
    return {q, x[DIGIT_W-1:0]};
  endfunction

endpackage

FILE: hdl/ratalu_mul.sv
`timescale 1ns / 1ps
// Shared magnitude multiplier with a registered product.
// Depends on ratalu_pkg for the default operand width.
module ratalu_mul #(
  parameter int OPERAND_WIDTH = ratalu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic [OPERAND_WIDTH-1:0]   x,
  input  logic [OPERAND_WIDTH-1:0]   y,
  output logic [2*OPERAND_WIDTH-1:0] prod
);
  import ratalu_pkg::*;

  always_ff @(posedge clk) begin
    prod <= {{OPERAND_WIDTH{1'b0}}, x} * {{OPERAND_WIDTH{1'b0}}, y};
  end

endmodule

FILE: hdl/ratalu_div.sv
`timescale 1ns / 1ps
// Digit-serial divider by a small constant, two lanes (numerator, denominator).
// Depends on ratalu_pkg for the divisor codes, the step function and the structs.
module ratalu_div #(
  parameter int OPERAND_WIDTH = ratalu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ratalu_pkg::div_ctl_t          ctl,
  input  logic [2*OPERAND_WIDTH-1:0]    n_in,
  input  logic [2*OPERAND_WIDTH-1:0]    d_in,
  output ratalu_pkg::div_sts_t          sts,
  output logic [2*OPERAND_WIDTH-1:0]    n_quo,
  output logic [2*OPERAND_WIDTH-1:0]    d_quo
);
  import ratalu_pkg::*;

  localparam int MAG_W = 2 * OPERAND_WIDTH;
  localparam int NDIG  = (MAG_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIG_W = NDIG * DIGIT_W;
  localparam int CNT_W = (NDIG > 2) ? $clog2(NDIG) : 1;

  logic [DIG_W-1:0]     nq;
  logic [DIG_W-1:0]     dq;
  logic [DIGIT_W-1:0]   rn;
  logic [DIGIT_W-1:0]   rd;
  logic [DIGIT_W-1:0]   p_reg;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic [2*DIGIT_W-1:0] n_step;
  logic [2*DIGIT_W-1:0] d_step;

  assign n_step = div_step(rn, nq[DIG_W-1 -: DIGIT_W], p_reg);
  assign d_step = div_step(rd, dq[DIG_W-1 -: DIGIT_W], p_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NDIG - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Quotient digits shift in from the bottom as dividend digits leave the top
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      nq    <= DIG_W'(n_in);
      dq    <= DIG_W'(d_in);
      rn    <= '0;
      rd    <= '0;
      p_reg <= prime_val(ctl.sel);
    end else if (busy) begin
      nq <= {nq[DIG_W-DIGIT_W-1:0], n_step[2*DIGIT_W-1:DIGIT_W]};
      dq <= {dq[DIG_W-DIGIT_W-1:0], d_step[2*DIGIT_W-1:DIGIT_W]};
      rn <= n_step[DIGIT_W-1:0];
      rd <= d_step[DIGIT_W-1:0];
    end
  end

  assign sts.done  = done;
  assign sts.n_div = (rn == '0);
  assign sts.d_div = (rd == '0);
  assign n_quo     = nq[MAG_W-1:0];
  assign d_quo     = dq[MAG_W-1:0];

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a preceding step");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !busy)
    else $error("divider restarted while busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (busy || done) |-> (rn < p_reg) && (rd < p_reg))
    else $error("divider remainder not below divisor");

endmodule

FILE: hdl/rational_alu_with_reduction_unit.sv
`timescale 1ns / 1ps
// Rational ALU with partial reduction: top level, sequencer and datapath registers.
// Depends on ratalu_pkg, ratalu_mul and ratalu_div.
//
// Usage
//   Input channel (in_valid/in_ready) carries one beat: command and two signed
//   fractions a_num/a_den, b_num/b_den. Output channel (out_valid/out_ready)
//   returns one beat per input: res_num, res_den, dec_shift and status.
//   One item is in flight at a time; in_ready is high only while idle.
// Timing
//   Cross products come from one registered multiplier, one product a cycle,
//   in S_MUL_A, S_MUL_B, S_MUL_C and S_COMB before the zero-over-zero check in
//   S_CHECK. Every trial division then runs through the shared digit-serial
//   divider, one radix-16 digit of numerator and denominator a cycle, over
//   NDIG = ceil(2 * OPERAND_WIDTH / 4) digits (8 at the default width).
//   Trials = 4 when no 2, 3, 5 or 7 is shared (11 and 13 are then left alone),
//   else 7 + one per shared factor stripped; add one per ten tested unless the
//   denominator has reduced to zero.
//   A zero-over-zero item skips all trials.
//   The next input beat is taken in the cycle after the result beat, at the earliest.
// Reset and stalls
//   rst (synchronous) returns the sequencer to idle and drops any item.
//   A stalled result beat is held in its output register until out_ready.
module rational_alu_with_reduction_unit #(
  parameter int OPERAND_WIDTH = ratalu_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic signed [OPERAND_WIDTH-1:0]     a_num,
  input  logic signed [OPERAND_WIDTH-1:0]     a_den,
  input  logic signed [OPERAND_WIDTH-1:0]     b_num,
  input  logic signed [OPERAND_WIDTH-1:0]     b_den,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ratalu_pkg::RES_W-1:0] res_num,
  output logic signed [ratalu_pkg::RES_W-1:0] res_den,
  output logic [ratalu_pkg::DEC_SHIFT_W-1:0]  dec_shift,
  output logic [ratalu_pkg::STATUS_W-1:0]     status
);
  import ratalu_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int MAG_W = 2 * OPERAND_WIDTH;
  localparam int EXT_W = MAG_W + RES_W;

  state_t state;
  state_t state_next;

  // operand magnitudes and signs
  cmd_t         cmd;
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic         an_neg, ad_neg, bn_neg, bd_neg;

  // working fraction
  logic [MAG_W-1:0] num_mag, den_mag;
  logic             num_neg, den_neg;
  prime_t           prime;
  logic [SHIFT_W-1:0] shift;
  logic             pass_hit;

  // result registers
  logic [RES_W-1:0] res_num_r, res_den_r;
  status_t          res_status;

  // shared units
  logic [W-1:0]     mul_x, mul_y;
  logic [MAG_W-1:0] prod;
  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [MAG_W-1:0] n_quo, d_quo;

  // combine step
  logic             t_neg;
  logic [MAG_W-1:0] sum_ab;
  logic [MAG_W:0]   diff_ab;
  logic [MAG_W-1:0] diff_ba;
  logic [MAG_W-1:0] comb_mag;
  logic             comb_neg;

  logic in_fire;
  logic both_zero;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] raw);
    return raw[W-1] ? (~raw + 1'b1) : raw;
  endfunction

  function automatic logic [RES_W-1:0] to_out(input logic neg, input logic [MAG_W-1:0] mag);
    logic [EXT_W-1:0] ext;
    ext = {{RES_W{1'b0}}, mag};
    if (neg) begin
      ext = ~ext + 1'b1;
    end
    return ext[RES_W-1:0];
  endfunction

  ratalu_mul #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_mul (
    .clk  (clk),
    .x    (mul_x),
    .y    (mul_y),
    .prod (prod)
  );

  ratalu_div #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_div (
    .clk   (clk),
    .rst   (rst),
    .ctl   (div_ctl),
    .n_in  (num_mag),
    .d_in  (den_mag),
    .sts   (div_sts),
    .n_quo (n_quo),
    .d_quo (d_quo)
  );

  assign in_fire   = in_valid && in_ready;
  assign both_zero = (num_mag == '0) && (den_mag == '0);

  // Signed add of the running numerator and the second cross product.
  // Subtract flips the sign of the second term.
  assign t_neg   = (prod != '0) && (ad_neg ^ bn_neg ^ (cmd == CMD_SUB));
  assign sum_ab  = num_mag + prod;
  assign diff_ab = {1'b0, num_mag} - {1'b0, prod};
  assign diff_ba = prod - num_mag;

  always_comb begin
    if (num_neg == t_neg) begin
      comb_mag = sum_ab;
      comb_neg = num_neg;
    end else if (!diff_ab[MAG_W]) begin
      comb_mag = diff_ab[MAG_W-1:0];
      comb_neg = num_neg;
    end else begin
      comb_mag = diff_ba;
      comb_neg = t_neg;
    end
    if (comb_mag == '0) begin
      comb_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_MUL_A;
        end
      end
      S_MUL_A: state_next = S_MUL_B;
      S_MUL_B: state_next = S_MUL_C;
      S_MUL_C: state_next = S_COMB;
      S_COMB:  state_next = S_CHECK;
      S_CHECK: begin
        // zero over zero would never leave the strip loop: classify at once
        state_next = both_zero ? S_CLASS : S_TRIAL;
      end
      S_TRIAL: state_next = S_WAIT;
      S_WAIT: begin
        if (div_sts.done) begin
          if (div_sts.n_div && div_sts.d_div) begin
            state_next = S_TRIAL;
          end else if (prime == P_13 || (prime == P_7 && !pass_hit)) begin
            // with no shared 2, 3, 5 or 7 the rest of the pass (10, 11, 13) is skipped
            state_next = (den_mag == '0) ? S_CLASS : S_TEN;
          end else begin
            state_next = S_TRIAL;
          end
        end
      end
      S_TEN:   state_next = S_TEN_WAIT;
      S_TEN_WAIT: begin
        if (div_sts.done) begin
          state_next = div_sts.d_div ? S_TEN : S_CLASS;
        end
      end
      S_CLASS: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes, multiplier operands, divider start
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    mul_x         = ad_m;
    mul_y         = bn_m;
    div_ctl.start = 1'b0;
    div_ctl.sel   = prime;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_MUL_A: begin
        mul_x = an_m;
        mul_y = (cmd == CMD_MUL) ? bn_m : bd_m;
      end
      S_MUL_B: begin
        mul_x = ad_m;
        mul_y = (cmd == CMD_DIV) ? bn_m : bd_m;
      end
      S_TRIAL: div_ctl.start = 1'b1;
      S_TEN: begin
        div_ctl.start = 1'b1;
        div_ctl.sel   = P_10;
      end
      S_OUT: out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  // Datapath registers. One strip pass suffices: dividing both terms by a
  // common factor never creates a new shared 2, 3, 5 or 7. The pass only
  // counts when it stripped one of those; otherwise 11 and 13 stay put.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd    <= cmd_t'(command);
          an_m   <= mag_of(a_num);
          ad_m   <= mag_of(a_den);
          bn_m   <= mag_of(b_num);
          bd_m   <= mag_of(b_den);
          an_neg <= a_num[W-1];
          ad_neg <= a_den[W-1];
          bn_neg <= b_num[W-1];
          bd_neg <= b_den[W-1];
          shift  <= '0;
        end
      end
      S_MUL_B: begin
        num_mag <= prod;
        num_neg <= (prod != '0) && (an_neg ^ ((cmd == CMD_MUL) ? bn_neg : bd_neg));
      end
      S_MUL_C: begin
        den_mag <= prod;
        den_neg <= (prod != '0) && (ad_neg ^ ((cmd == CMD_DIV) ? bn_neg : bd_neg));
      end
      S_COMB: begin
        if (cmd == CMD_ADD || cmd == CMD_SUB) begin
          num_mag <= comb_mag;
          num_neg <= comb_neg;
        end
      end
      S_CHECK: begin
        prime    <= P_2;
        pass_hit <= 1'b0;
      end
      S_WAIT: begin
        if (div_sts.done) begin
          if (div_sts.n_div && div_sts.d_div) begin
            num_mag  <= n_quo;
            den_mag  <= d_quo;
            pass_hit <= 1'b1;
          end else begin
            prime <= next_prime(prime);
          end
        end
      end
      S_TEN_WAIT: begin
        if (div_sts.done && div_sts.d_div) begin
          den_mag <= d_quo;
          shift   <= shift + 1'b1;
        end
      end
      S_CLASS: begin
        res_num_r <= to_out(num_neg, num_mag);
        res_den_r <= to_out(den_neg, den_mag);
        if (den_mag == '0) begin
          res_status <= ST_UNDEF;
        end else if (shift != '0) begin
          res_status <= ST_DEC;
        end else if (num_mag == '0) begin
          res_status <= ST_ZERO;
        end else if (den_mag == MAG_W'(1) && !den_neg) begin
          res_status <= ST_INT;
        end else begin
          res_status <= ST_FRAC;
        end
      end
      default: begin
      end
    endcase
  end

  assign res_num   = res_num_r;
  assign res_den   = res_den_r;
  assign dec_shift = shift[DEC_SHIFT_W-1:0];
  assign status    = res_status;

  a_dec_has_shift: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_status == ST_DEC) |-> (shift != '0))
    else $error("decimal result without a stripped ten");

  a_shift_only_dec: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_status != ST_DEC) |-> (shift == '0))
    else $error("tens stripped on a non-decimal result");

  a_undef_den_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_status == ST_UNDEF) |-> (res_den_r == '0))
    else $error("undefined result with nonzero denominator");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> (state == S_WAIT || state == S_TEN_WAIT))
    else $error("divider finished outside a wait state");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rational_alu_with_reduction_unit: directed and random beats
// checked against an in-bench model of the cross products and trial-division reduction.
// Depends on ratalu_pkg and the RTL under hdl/.
module tb_top;
  import ratalu_pkg::*;

  localparam int OW       = OPERAND_WIDTH_DEF;
  localparam int N_RANDOM = 750;
  localparam int DRAIN    = 1100;   // beyond the longest trial sequence of one item

  typedef struct {
    cmd_t                 op;
    logic signed [OW-1:0] an;
    logic signed [OW-1:0] ad;
    logic signed [OW-1:0] bn;
    logic signed [OW-1:0] bd;
  } op_item_t;

  typedef struct {
    logic signed [RES_W-1:0] num;
    logic signed [RES_W-1:0] den;
    logic [DEC_SHIFT_W-1:0]  shift;
    status_t                 st;
  } rat_res_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               command = CMD_ADD;
  logic signed [OW-1:0]     a_num = '0;
  logic signed [OW-1:0]     a_den = '0;
  logic signed [OW-1:0]     b_num = '0;
  logic signed [OW-1:0]     b_den = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [RES_W-1:0]  res_num;
  logic signed [RES_W-1:0]  res_den;
  logic [DEC_SHIFT_W-1:0]   dec_shift;
  logic [STATUS_W-1:0]      status;

  op_item_t pending_ops[$];
  rat_res_t due_results[$];
  int       n_items;
  int       n_sent = 0;
  int       n_taken = 0;
  int       n_mismatch = 0;
  logic     in_beat_taken = 1'b0;
  logic     calm;

  rational_alu_with_reduction_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .a_num     (a_num),
    .a_den     (a_den),
    .b_num     (b_num),
    .b_den     (b_den),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_num   (res_num),
    .res_den   (res_den),
    .dec_shift (dec_shift),
    .status    (status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // No idling on either side while this window of beats goes by
  assign calm = (n_sent >= 300) && (n_sent < 420);

  function automatic bit shares_factor(longint unsigned n, longint unsigned d,
                                       longint unsigned p);
    return (n % p == 0) && (d % p == 0);
  endfunction

  // Exact cross products, then strip shared small factors pass by pass until
  // no 2, 3, 5 or 7 is shared; sign rides along untouched.
  function automatic rat_res_t reduce_quotient(op_item_t it);
    longint          an, ad, bn, bd, sn, sd;
    longint unsigned n, d;
    logic            nneg, dneg;
    longint unsigned divs [7] = '{2, 3, 5, 7, 10, 11, 13};
    rat_res_t        r;
    an = it.an;
    ad = it.ad;
    bn = it.bn;
    bd = it.bd;
    case (it.op)
      CMD_ADD: begin
        sn = an * bd + ad * bn;
        sd = ad * bd;
      end
      CMD_SUB: begin
        sn = an * bd - ad * bn;
        sd = ad * bd;
      end
      CMD_MUL: begin
        sn = an * bn;
        sd = ad * bd;
      end
      default: begin
        sn = an * bd;
        sd = ad * bn;
      end
    endcase
    r.num   = '0;
    r.den   = '0;
    r.shift = '0;
    r.st    = ST_UNDEF;
    if (sn == 0 && sd == 0) return r;
    nneg = sn < 0;
    dneg = sd < 0;
    n = nneg ? -sn : sn;
    d = dneg ? -sd : sd;
    while (shares_factor(n, d, 2) || shares_factor(n, d, 3) ||
           shares_factor(n, d, 5) || shares_factor(n, d, 7)) begin
      foreach (divs[i]) begin
        while (shares_factor(n, d, divs[i])) begin
          n = n / divs[i];
          d = d / divs[i];
        end
      end
    end
    if (d == 0) begin
      r.st = ST_UNDEF;
    end else if (d % 10 == 0) begin
      while (d % 10 == 0) begin
        d = d / 10;
        r.shift++;
      end
      r.st = ST_DEC;
    end else if (n == 0) begin
      r.st = ST_ZERO;
    end else if (d == 1 && !dneg) begin
      r.st = ST_INT;
    end else begin
      r.st = ST_FRAC;
    end
    r.num = RES_W'(nneg ? -n : n);
    r.den = RES_W'(dneg ? -d : d);
    return r;
  endfunction

  // Mix of full-range noise, small values, smooth numbers, extremes and powers of ten
  function automatic logic signed [OW-1:0] pick_operand();
    int v;
    int f;
    int smooth [4] = '{2, 3, 5, 7};
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom);
      3, 4:    v = $urandom_range(0, 40) - 20;
      5, 6: begin
        v = 1;
        repeat ($urandom_range(1, 10)) begin
          f = smooth[$urandom_range(0, 3)];
          if (v * f <= 32767) v = v * f;
        end
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      7: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      default: begin
        v = $urandom_range(1, 3);
        repeat ($urandom_range(0, 4)) v = v * 10;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v[OW-1:0];
  endfunction

  task automatic queue_op(cmd_t op, int an, int ad, int bn, int bd);
    op_item_t it;
    it.op = op;
    it.an = an[OW-1:0];
    it.ad = ad[OW-1:0];
    it.bn = bn[OW-1:0];
    it.bd = bd[OW-1:0];
    pending_ops.push_back(it);
  endtask

  task automatic note_mismatch(string what);
    n_mismatch++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // Stimulus and end of run
  initial begin
    op_item_t it;
    queue_op(CMD_ADD, 1, 2, 1, 5);             // decimal, nothing left below the point
    queue_op(CMD_MUL, 1, 3, 1, 10);            // decimal with a remaining denominator
    queue_op(CMD_MUL, -1, 2, 1, 5);            // negative decimal
    queue_op(CMD_MUL, 1, 1000, 1, 10000);      // many tens
    queue_op(CMD_MUL, 1, -1000, 3, -10);
    queue_op(CMD_MUL, 0, 0, 5, 7);             // zero over zero
    queue_op(CMD_ADD, 0, 0, 0, 0);
    queue_op(CMD_MUL, 2, 0, 0, 3);
    queue_op(CMD_DIV, 3, 4, 0, 5);             // nonzero over zero
    queue_op(CMD_SUB, 5, 0, 1, 1);
    queue_op(CMD_MUL, 0, 1, 5, 7);             // zero
    queue_op(CMD_SUB, 1, 2, 1, 2);
    queue_op(CMD_ADD, 0, 3, 0, -7);            // zero with a negative denominator
    queue_op(CMD_MUL, 3, -1, 1, 1);            // n over minus one stays a fraction
    queue_op(CMD_MUL, 6, 3, 1, 1);             // integer
    queue_op(CMD_DIV, 1, 2, 1, 2);
    queue_op(CMD_ADD, 1, 1, 1, 1);
    queue_op(CMD_MUL, 30030, 1, 1, 30030);     // every trial divisor in play
    queue_op(CMD_MUL, 7, 13, 11, 13);
    queue_op(CMD_MUL, 11, 1, 1, 22);           // shared 11 alone is kept
    queue_op(CMD_MUL, 0, 1, 1, 13);
    queue_op(CMD_ADD, 32767, 32767, 32767, 32767);
    queue_op(CMD_MUL, -32768, -32768, -32768, -32768);
    queue_op(CMD_SUB, -32768, 1, 32767, 1);
    queue_op(CMD_DIV, 32767, -32768, -32768, 32767);
    queue_op(CMD_DIV, -1, -1, -1, -1);
    repeat (N_RANDOM) begin
      it.op = cmd_t'($urandom_range(0, 3));
      it.an = pick_operand();
      it.ad = pick_operand();
      it.bn = pick_operand();
      it.bd = pick_operand();
      pending_ops.push_back(it);
    end
    n_items = pending_ops.size();

    while (n_taken < n_items || due_results.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (n_mismatch == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: hold a beat until it is taken, then offer the next one or idle
  always @(negedge clk) begin : drive_beats
    op_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 26)) begin
        it = pending_ops.pop_front();
        command  <= it.op;
        a_num    <= it.an;
        a_den    <= it.ad;
        b_num    <= it.bn;
        b_den    <= it.bd;
        in_valid <= 1'b1;
        n_sent   <= n_sent + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !rst && (calm || $urandom_range(0, 99) >= 26);
  end

  // Monitor: predict on each accepted input beat, check each accepted result beat
  always @(posedge clk) begin : watch_beats
    op_item_t it;
    rat_res_t want;
    if (rst) begin
      in_beat_taken <= 1'b0;
    end else begin
      in_beat_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        it.op = cmd_t'(command);
        it.an = a_num;
        it.ad = a_den;
        it.bn = b_num;
        it.bd = b_den;
        due_results.push_back(reduce_quotient(it));
        n_taken <= n_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          note_mismatch("result beat with nothing expected");
        end else begin
          want = due_results.pop_front();
          if (res_num !== want.num)
            note_mismatch($sformatf("res_num %0d, expected %0d", res_num, want.num));
          if (res_den !== want.den)
            note_mismatch($sformatf("res_den %0d, expected %0d", res_den, want.den));
          if (dec_shift !== want.shift)
            note_mismatch($sformatf("dec_shift %0d, expected %0d", dec_shift, want.shift));
          if (status !== want.st)
            note_mismatch($sformatf("status %0d, expected %0d", status, want.st));
        end
      end
    end
  end

endmodule

FILE: files.f
hdl/ratalu_pkg.sv
hdl/ratalu_mul.sv
hdl/ratalu_div.sv
hdl/rational_alu_with_reduction_unit.sv
test/tb_top.sv
